@@ src/erc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the e-paper refresh controller.
// No dependencies; imported by every module of the block.
package erc_pkg;

  typedef enum logic [3:0] {
    PH_UNINIT      = 4'd0,
    PH_RESET_HIGH  = 4'd1,
    PH_RESET_LOW   = 4'd2,
    PH_RESET_DONE  = 4'd3,
    PH_INIT_CMDS   = 4'd4,
    PH_INIT_WAIT   = 4'd5,
    PH_IDLE        = 4'd6,
    PH_PREPARE     = 4'd7,
    PH_SEND        = 4'd8,
    PH_REFRESH     = 4'd9,
    PH_REF_WAIT    = 4'd10,
    PH_SLEEP       = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    CMD_POLL     = 2'd0,
    CMD_UPDATE   = 2'd1,
    CMD_SHUTDOWN = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_INIT      = 3'd1,
    ACT_PREPARE   = 3'd2,
    ACT_SEND      = 3'd3,
    ACT_FULL      = 3'd4,
    ACT_PARTIAL   = 3'd5,
    ACT_SLEEP     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    RST_NONE = 2'd0,
    RST_LOW  = 2'd1,
    RST_HIGH = 2'd2
  } rst_wr_t;

  typedef enum logic [1:0] {
    WARN_NONE     = 2'd0,
    WARN_INIT     = 2'd1,
    WARN_PREPARE  = 2'd2,
    WARN_REFRESH  = 2'd3
  } warn_t;

  typedef enum logic [1:0] {
    CFG_HAS_RESET  = 2'd0,
    CFG_HAS_BUSY   = 2'd1,
    CFG_BUSY_LEVEL = 2'd2,
    CFG_FULL_EVERY = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_TAKE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2
  } ctrl_state_t;

  localparam int unsigned CFG_W = 16;

  localparam logic [31:0] LOW_HOLD_MS      = 32'd100;
  localparam logic [31:0] HIGH_SETTLE_MS   = 32'd10;
  localparam logic [31:0] BUSY_LIMIT_MS    = 32'd2000;
  localparam logic [31:0] REFRESH_LIMIT_MS = 32'd60000;

  localparam logic [15:0] FULL_EVERY_RST = 16'd10;

  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

@@ src/erc_rem.sv @@
`timescale 1ns / 1ps
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on erc_pkg.
module erc_rem
  import erc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic        run_r, run_nxt;
  logic        fin_r, fin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[31]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    run_nxt = run_r;
    fin_nxt = 1'b0;
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub[15:0];
      end else begin
        rem_nxt = rem_sh[15:0];
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == '1) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = fin_r;
  assign remainder = rem_r;

endmodule

@@ src/erc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration, item and panel state registers, step logic, result register.
// Depends on erc_pkg and erc_rem.
module erc_datapath
  import erc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_now_ms,
  input  logic              in_busy_line,
  input  logic              in_want_full,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [2:0]        out_action,
  output logic [1:0]        out_reset_write,
  output logic [1:0]        out_warning,
  output logic [3:0]        out_phase_now,
  output logic [31:0]       out_update_number,
  output logic              out_full_refresh,
  output logic              out_park
);

  // configuration
  logic        has_rst_r;
  logic        has_busy_r;
  logic        busy_lvl_r;
  logic [15:0] full_every_r;

  // latched item
  cmd_t        cmd_r;
  logic [31:0] now_r;
  logic        line_r;
  logic        want_r;

  // panel state
  phase_t      phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic        upd_r, upd_nxt;
  logic        force_r, force_nxt;
  logic [31:0] count_r, count_nxt;
  logic        full_r, full_nxt;

  // result
  action_t     act_r, act_nxt;
  rst_wr_t     rstw_r, rstw_nxt;
  warn_t       warn_r, warn_nxt;
  phase_t      ph_out_r;
  logic [31:0] cnt_out_r;
  logic        full_out_r;
  logic        park_r, park_nxt;

  logic [31:0] elapsed;
  logic [31:0] count_inc;
  logic        busy;
  logic        periodic;
  logic        div_done;
  logic [15:0] rem;

  erc_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_div),
    .dividend  (count_inc),
    .divisor   (full_every_r),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_rst_r    <= 1'b1;
      has_busy_r   <= 1'b1;
      busy_lvl_r   <= 1'b1;
      full_every_r <= FULL_EVERY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HAS_RESET:  has_rst_r    <= cfg_wdata[0];
        CFG_HAS_BUSY:   has_busy_r   <= cfg_wdata[0];
        CFG_BUSY_LEVEL: busy_lvl_r   <= cfg_wdata[0];
        CFG_FULL_EVERY: full_every_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= cmd_t'(in_command);
      now_r  <= in_now_ms;
      line_r <= in_busy_line;
      want_r <= in_want_full;
    end
  end

  always_comb begin
    elapsed   = now_r - start_r;
    count_inc = count_r + 32'd1;
    busy      = has_busy_r && (line_r == busy_lvl_r);
    periodic  = (full_every_r != 16'd0) && (rem == 16'd0);

    phase_nxt = phase_r;
    start_nxt = start_r;
    upd_nxt   = upd_r;
    force_nxt = force_r;
    count_nxt = count_r;
    full_nxt  = full_r;
    act_nxt   = ACT_NONE;
    rstw_nxt  = RST_NONE;
    warn_nxt  = WARN_NONE;

    case (cmd_r)
      CMD_UPDATE: begin
        upd_nxt = 1'b1;
        if (want_r) begin
          force_nxt = 1'b1;
        end
      end
      CMD_SHUTDOWN: begin
        act_nxt   = ACT_SLEEP;
        phase_nxt = PH_SLEEP;
      end
      CMD_POLL: begin
        case (phase_r)
          PH_RESET_HIGH: begin
            if (has_rst_r) begin
              rstw_nxt  = RST_HIGH;
              phase_nxt = PH_RESET_LOW;
              start_nxt = now_r;
            end else begin
              phase_nxt = PH_INIT_CMDS;
            end
          end
          PH_RESET_LOW: begin
            if (elapsed >= LOW_HOLD_MS) begin
              rstw_nxt  = has_rst_r ? RST_LOW : RST_NONE;
              phase_nxt = PH_RESET_DONE;
              start_nxt = now_r;
            end
          end
          PH_RESET_DONE: begin
            if (elapsed >= HIGH_SETTLE_MS) begin
              rstw_nxt  = has_rst_r ? RST_HIGH : RST_NONE;
              phase_nxt = PH_INIT_CMDS;
              start_nxt = now_r;
            end
          end
          PH_INIT_CMDS: begin
            if (elapsed >= HIGH_SETTLE_MS) begin
              act_nxt   = ACT_INIT;
              phase_nxt = PH_INIT_WAIT;
              start_nxt = now_r;
            end
          end
          PH_INIT_WAIT: begin
            if (!busy) begin
              phase_nxt = PH_IDLE;
            end else if (elapsed > BUSY_LIMIT_MS) begin
              warn_nxt  = WARN_INIT;
              phase_nxt = PH_IDLE;
            end
          end
          PH_IDLE: begin
            if (upd_r) begin
              upd_nxt   = 1'b0;
              count_nxt = count_inc;
              full_nxt  = force_r || (count_inc == 32'd1) || periodic;
              force_nxt = 1'b0;
              phase_nxt = PH_PREPARE;
              start_nxt = now_r;
            end
          end
          PH_PREPARE: begin
            if (!busy) begin
              act_nxt   = ACT_PREPARE;
              phase_nxt = PH_SEND;
              start_nxt = now_r;
            end else if (elapsed > BUSY_LIMIT_MS) begin
              warn_nxt  = WARN_PREPARE;
              act_nxt   = ACT_PREPARE;
              phase_nxt = PH_SEND;
              start_nxt = now_r;
            end
          end
          PH_SEND: begin
            act_nxt   = ACT_SEND;
            phase_nxt = PH_REFRESH;
            start_nxt = now_r;
          end
          PH_REFRESH: begin
            act_nxt   = full_r ? ACT_FULL : ACT_PARTIAL;
            phase_nxt = PH_REF_WAIT;
            start_nxt = now_r;
          end
          PH_REF_WAIT: begin
            if (!busy) begin
              phase_nxt = PH_IDLE;
            end else if (elapsed > REFRESH_LIMIT_MS) begin
              warn_nxt  = WARN_REFRESH;
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    park_nxt = ((phase_nxt == PH_IDLE) && !upd_nxt) || (phase_nxt == PH_SLEEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RESET_HIGH;
      start_r <= '0;
      upd_r   <= 1'b0;
      force_r <= 1'b0;
      count_r <= '0;
      full_r  <= 1'b0;
    end else if (cmd.commit) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      upd_r   <= upd_nxt;
      force_r <= force_nxt;
      count_r <= count_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      act_r      <= act_nxt;
      rstw_r     <= rstw_nxt;
      warn_r     <= warn_nxt;
      ph_out_r   <= phase_nxt;
      cnt_out_r  <= count_nxt;
      full_out_r <= full_nxt;
      park_r     <= park_nxt;
    end
  end

  assign stat.need_div = (cmd_r == CMD_POLL) && (phase_r == PH_IDLE) && upd_r;
  assign stat.div_done = div_done;

  assign out_action        = act_r;
  assign out_reset_write   = rstw_r;
  assign out_warning       = warn_r;
  assign out_phase_now     = ph_out_r;
  assign out_update_number = cnt_out_r;
  assign out_full_refresh  = full_out_r;
  assign out_park          = park_r;

endmodule

@@ src/erc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: item handshake, step sequencing and result valid flag.
// Depends on erc_pkg.
module erc_ctrl
  import erc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t st_r, st_nxt;
  logic        ov_r, ov_nxt;
  logic        room;
  logic        take;

  assign room = !ov_r || !out_stall;

  always_comb begin
    st_nxt        = st_r;
    cmd.load      = 1'b0;
    cmd.start_div = 1'b0;
    cmd.commit    = 1'b0;
    take          = 1'b0;
    case (st_r)
      ST_TAKE: begin
        take = room && rst_n;
        if (in_valid && take) begin
          cmd.load = 1'b1;
          st_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.need_div) begin
          cmd.start_div = 1'b1;
          st_nxt        = ST_DIV;
        end else begin
          cmd.commit = 1'b1;
          st_nxt     = ST_TAKE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          st_nxt     = ST_TAKE;
        end
      end
      default: st_nxt = ST_TAKE;
    endcase

    ov_nxt = ov_r;
    if (cmd.commit) begin
      ov_nxt = 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_TAKE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_stall  = !take;
  assign out_valid = ov_r;

endmodule

@@ src/epaper_refresh_controller_top.sv @@
`timescale 1ns / 1ps
// Top level of the e-paper refresh controller: controller plus datapath.
// Depends on erc_pkg, erc_ctrl and erc_datapath.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_command, in_now_ms, in_busy_line, in_want_full
//   out      out_valid/out_stall out_action .. out_park (one result per item)
//   cfg      cfg_we              cfg_index, cfg_wdata (no read-back)
//
// An item is first accepted, then evaluated, and the result register is loaded.
// An idle poll that starts a pending update also waits for the
// one-bit-per-cycle remainder unit that checks the periodic full refresh.
// Reset is synchronous and active low; configuration returns to its defaults.
// A stalled result holds; the next item is taken in the cycle it is removed.
module epaper_refresh_controller_top
  import erc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_now_ms,
  input  logic              in_busy_line,
  input  logic              in_want_full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [1:0]        out_reset_write,
  output logic [1:0]        out_warning,
  output logic [3:0]        out_phase_now,
  output logic [31:0]       out_update_number,
  output logic              out_full_refresh,
  output logic              out_park
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  erc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  erc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_command),
    .in_now_ms         (in_now_ms),
    .in_busy_line      (in_busy_line),
    .in_want_full      (in_want_full),
    .cmd               (cmd),
    .stat              (stat),
    .out_action        (out_action),
    .out_reset_write   (out_reset_write),
    .out_warning       (out_warning),
    .out_phase_now     (out_phase_now),
    .out_update_number (out_update_number),
    .out_full_refresh  (out_full_refresh),
    .out_park          (out_park)
  );

endmodule
